@@ rtl/spm_pkg.sv @@
// Shared constants, types and state codes for the split-array min-largest-sum block.
`timescale 1ns / 1ps

package spm_pkg;

    localparam int MAX_ITEMS = 1024;
    localparam int MAX_PARTS = 64;

    localparam int VAL_W  = 32;
    localparam int SUM_W  = 48;
    localparam int CFG_W  = 7;
    localparam int ADDR_W = $clog2(MAX_ITEMS + 1);
    localparam int PART_W = $clog2(MAX_PARTS + 1);

    typedef enum logic [2:0] {
        S_LOAD,
        S_PI_RD,
        S_PI_WAIT,
        S_K_LOOP,
        S_DRAIN,
        S_RESULT
    } t_state;

    // Control from the sequencer to the shared compare unit.
    typedef struct packed {
        logic clear;      // start a new row: best goes to all ones
        logic issue;      // a split point is being read this cycle
        logic k_zero;     // split point is zero: prefix reads as 0
        logic left_zero;  // first column: left part costs nothing
    } t_unit_ctl;

endpackage

@@ rtl/split_array_min_largest_sum.sv @@
// Top level: load prefix sums, run the partition DP column by column, return the result.
//
// Input channel (i_valid / o_stall): one word per cycle while loading; i_last ends a
// sequence. Words beyond 1024 are dropped, but a dropped word with i_last still ends it.
// Configuration: i_cfg_wr_en writes i_cfg_wr_data into part_count (reset value 1);
// counts above 64 act as 64. Write it only while the block is idle.
// After the last word, o_stall stays high while the DP runs. Row i of column j walks
// split points one per cycle through one shared subtract/max/min unit; one memory read
// port per column memory and the prefix memory set this pace. Fewer words than parts
// (or a part count of zero) skips the DP: the block goes straight to S_RESULT and then
// raises o_valid, flagging infeasible, once the output register is free.
// Output channel (o_valid / i_stall): one word per sequence, held in an output register
// while i_stall is high. Loading of the next sequence proceeds meanwhile; its result
// waits until the previous one is taken.
// Reset (i_rst_n low, synchronous) empties the sequence, drops any pending result and
// sets part_count to 1.
`timescale 1ns / 1ps

module split_array_min_largest_sum (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [spm_pkg::CFG_W-1:0] i_cfg_wr_data,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [spm_pkg::VAL_W-1:0] i_value,
    input  logic                      i_last,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [spm_pkg::SUM_W-1:0] o_best_largest_sum,
    output logic                      o_infeasible
);

    import spm_pkg::*;

    t_state            r_state, n_state;
    logic [CFG_W-1:0]  r_part_count;
    logic [ADDR_W-1:0] r_cnt, n_cnt;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [ADDR_W-1:0] r_n, n_n;
    logic [PART_W-1:0] r_m, n_m;
    logic [ADDR_W-1:0] r_i, n_i;
    logic [ADDR_W-1:0] r_j, n_j;
    logic [ADDR_W-1:0] r_k, n_k;
    logic              r_sel, n_sel;
    logic              r_inf, n_inf;
    logic              r_o_vld, n_o_vld;
    logic [SUM_W-1:0]  r_pi, n_pi;
    logic [SUM_W-1:0]  r_best_out;
    logic              r_inf_out;

    logic              w_room;
    logic [PART_W-1:0] w_clip;
    logic [ADDR_W-1:0] w_n_last;
    logic [ADDR_W-1:0] w_k_end;
    logic              load_out;

    logic              pre_we;
    logic [ADDR_W-1:0] pre_waddr;
    logic [SUM_W-1:0]  pre_wdata;
    logic [ADDR_W-1:0] pre_raddr;
    logic [SUM_W-1:0]  pre_rdata;

    logic              col_we;
    logic [SUM_W-1:0]  col0_rdata;
    logic [SUM_W-1:0]  col1_rdata;
    logic [SUM_W-1:0]  w_left;

    t_unit_ctl         ctl;
    logic [SUM_W-1:0]  unit_best;
    logic              unit_busy;

    assign w_room   = (32'(r_cnt) < 32'(MAX_ITEMS));
    assign w_clip   = (32'(r_part_count) > 32'(MAX_PARTS)) ? PART_W'(MAX_PARTS)
                                                           : PART_W'(r_part_count);
    assign w_n_last = w_room ? (r_cnt + 1'b1) : r_cnt;
    // First column only uses split point zero; later ones run j-1 .. i-1.
    assign w_k_end  = (r_j == ADDR_W'(1)) ? '0 : (r_i - 1'b1);
    assign w_left   = r_sel ? col1_rdata : col0_rdata;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_sum     = r_sum;
        n_n       = r_n;
        n_m       = r_m;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        n_sel     = r_sel;
        n_inf     = r_inf;
        n_o_vld   = r_o_vld;
        n_pi      = r_pi;
        pre_we    = 1'b0;
        pre_waddr = r_cnt + 1'b1;
        pre_wdata = r_sum + SUM_W'(i_value);
        pre_raddr = r_k;
        ctl       = '0;
        col_we    = 1'b0;
        load_out  = 1'b0;

        if (r_o_vld && !i_stall) begin
            n_o_vld = 1'b0;
        end

        unique case (r_state)
            S_LOAD: begin
                if (i_valid) begin
                    if (w_room) begin
                        pre_we = 1'b1;
                        n_sum  = pre_wdata;
                        n_cnt  = r_cnt + 1'b1;
                    end
                    if (i_last) begin
                        n_n   = w_n_last;
                        n_m   = w_clip;
                        n_cnt = '0;
                        n_sum = '0;
                        n_j   = ADDR_W'(1);
                        n_i   = ADDR_W'(1);
                        n_sel = 1'b0;
                        if ((w_clip == '0) || (32'(w_n_last) < 32'(w_clip))) begin
                            n_inf   = 1'b1;
                            n_state = S_RESULT;
                        end else begin
                            n_inf   = 1'b0;
                            n_state = S_PI_RD;
                        end
                    end
                end
            end
            S_PI_RD: begin
                pre_raddr = r_i;
                n_state   = S_PI_WAIT;
            end
            S_PI_WAIT: begin
                n_pi      = pre_rdata;
                ctl.clear = 1'b1;
                n_k       = r_j - 1'b1;
                n_state   = S_K_LOOP;
            end
            S_K_LOOP: begin
                ctl.issue     = 1'b1;
                ctl.k_zero    = (r_k == '0);
                ctl.left_zero = (r_j == ADDR_W'(1));
                if (r_k == w_k_end) begin
                    n_state = S_DRAIN;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_DRAIN: begin
                // Write the row minimum once the unit has emptied.
                if (!unit_busy) begin
                    col_we = 1'b1;
                    if (r_i == r_n) begin
                        if (32'(r_j) == 32'(r_m)) begin
                            n_state = S_RESULT;
                        end else begin
                            n_j     = r_j + 1'b1;
                            n_i     = r_j + 1'b1;
                            n_sel   = ~r_sel;
                            n_state = S_PI_RD;
                        end
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = S_PI_RD;
                    end
                end
            end
            S_RESULT: begin
                if (!r_o_vld || !i_stall) begin
                    load_out = 1'b1;
                    n_o_vld  = 1'b1;
                    n_state  = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_part_count <= CFG_W'(1);
            r_cnt        <= '0;
            r_sum        <= '0;
            r_n          <= '0;
            r_m          <= '0;
            r_i          <= '0;
            r_j          <= '0;
            r_k          <= '0;
            r_sel        <= 1'b0;
            r_inf        <= 1'b0;
            r_o_vld      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_part_count <= i_cfg_wr_data;
            end
            r_cnt   <= n_cnt;
            r_sum   <= n_sum;
            r_n     <= n_n;
            r_m     <= n_m;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_sel   <= n_sel;
            r_inf   <= n_inf;
            r_o_vld <= n_o_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pi <= n_pi;
        if (load_out) begin
            r_best_out <= r_inf ? '0 : unit_best;
            r_inf_out  <= r_inf;
        end
    end

    spm_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_ITEMS + 1)
    ) u_prefix (
        .i_clk   (i_clk),
        .i_we    (pre_we),
        .i_waddr (pre_waddr),
        .i_wdata (pre_wdata),
        .i_raddr (pre_raddr),
        .o_rdata (pre_rdata)
    );

    // Column memories swap roles each column: r_sel names the previous one.
    spm_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_ITEMS + 1)
    ) u_col0 (
        .i_clk   (i_clk),
        .i_we    (col_we & r_sel),
        .i_waddr (r_i),
        .i_wdata (unit_best),
        .i_raddr (r_k),
        .o_rdata (col0_rdata)
    );

    spm_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_ITEMS + 1)
    ) u_col1 (
        .i_clk   (i_clk),
        .i_we    (col_we & ~r_sel),
        .i_waddr (r_i),
        .i_wdata (unit_best),
        .i_raddr (r_k),
        .o_rdata (col1_rdata)
    );

    spm_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_pi    (r_pi),
        .i_pk    (pre_rdata),
        .i_left  (w_left),
        .o_best  (unit_best),
        .o_busy  (unit_busy)
    );

    assign o_stall            = (r_state != S_LOAD);
    assign o_valid            = r_o_vld;
    assign o_best_largest_sum = r_best_out;
    assign o_infeasible       = r_inf_out;

    a_unit_idle_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> !unit_busy)
        else $error("compare unit busy while loading");

    a_split_below_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_K_LOOP) |-> ((r_k < r_i) && (r_i <= r_n)))
        else $error("split point or row index out of range");

    a_infeasible_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_infeasible) |-> (o_best_largest_sum == '0))
        else $error("infeasible result carries a nonzero sum");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= 32'(MAX_ITEMS))
        else $error("item count above capacity");

endmodule

@@ rtl/spm_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module spm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/spm_unit.sv @@
// Shared subtract / max / min unit: one split point per cycle, keeps the row minimum.
`timescale 1ns / 1ps

module spm_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  spm_pkg::t_unit_ctl        i_ctl,
    input  logic [spm_pkg::SUM_W-1:0] i_pi,
    input  logic [spm_pkg::SUM_W-1:0] i_pk,
    input  logic [spm_pkg::SUM_W-1:0] i_left,
    output logic [spm_pkg::SUM_W-1:0] o_best,
    output logic                      o_busy
);

    import spm_pkg::*;

    logic             r_rd_vld;
    logic             r_k_zero;
    logic             r_left_zero;
    logic             r_vb;
    logic [SUM_W-1:0] r_part;
    logic [SUM_W-1:0] r_left;
    logic [SUM_W-1:0] r_best;

    logic [SUM_W-1:0] w_pk;
    logic [SUM_W-1:0] w_left;
    logic [SUM_W-1:0] w_cand;

    assign w_pk   = r_k_zero ? '0 : i_pk;
    assign w_left = r_left_zero ? '0 : i_left;
    assign w_cand = (r_left > r_part) ? r_left : r_part;

    // Control flags track the memory read latency.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_vb     <= 1'b0;
        end else begin
            r_rd_vld <= i_ctl.issue;
            r_vb     <= r_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k_zero    <= i_ctl.k_zero;
        r_left_zero <= i_ctl.left_zero;
        r_part      <= i_pi - w_pk;
        r_left      <= w_left;
        if (i_ctl.clear) begin
            r_best <= '1;
        end else if (r_vb && (w_cand < r_best)) begin
            r_best <= w_cand;
        end
    end

    assign o_best = r_best;
    assign o_busy = r_rd_vld | r_vb;

endmodule

@@ dv/split_array_min_largest_sum_tb.sv @@
// Self-checking testbench for the split-array minimum-largest-sum block.
`timescale 1ns / 1ps

module split_array_min_largest_sum_tb;
    import spm_pkg::*;

    localparam int CYCLE_LIMIT = 5_000_000;
    localparam bit [SUM_W:0] UNREACHABLE = {1'b1, {SUM_W{1'b0}}};

    typedef struct packed {
        logic [SUM_W-1:0] largest_sum;
        logic             infeasible;
    } t_split_result;

    typedef enum int {
        MIX_STEADY,
        MIX_TX_GAPS,
        MIX_RX_STALLS,
        MIX_BOTH
    } t_idle_mode;

    typedef enum int {
        VAL_FULL,
        VAL_SMALL,
        VAL_EDGE
    } t_value_mix;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    logic [CFG_W-1:0] i_cfg_wr_data;
    logic             i_valid;
    logic             o_stall;
    logic [VAL_W-1:0] i_value;
    logic             i_last;
    logic             o_valid;
    logic             i_stall;
    logic [SUM_W-1:0] o_best_largest_sum;
    logic             o_infeasible;

    // Predictor state: prefix sums of the open sequence, DP columns, part setting.
    bit [SUM_W-1:0] seq_prefix [0:MAX_ITEMS];
    bit [SUM_W:0]   col_prev   [0:MAX_ITEMS];
    bit [SUM_W:0]   col_cur    [0:MAX_ITEMS];
    int unsigned    seq_len;
    bit [CFG_W-1:0] parts_setting;

    t_split_result split_results_due [$];

    t_idle_mode  idle_mode;
    int          rx_hold_left;
    int unsigned words_sent;
    int unsigned results_checked;
    int unsigned error_count;
    int unsigned cycle_count;

    split_array_min_largest_sum dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_value            (i_value),
        .i_last             (i_last),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_best_largest_sum (o_best_largest_sum),
        .o_infeasible       (o_infeasible)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     split_results_due.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int unsigned idle_pct(t_idle_mode mode, bit rx_side);
        case (mode)
            MIX_TX_GAPS:   return rx_side ? 0 : 45;
            MIX_RX_STALLS: return rx_side ? 45 : 0;
            MIX_BOTH:      return 17;
            default:       return 0;
        endcase
    endfunction

    function automatic bit [VAL_W-1:0] random_value(t_value_mix mix);
        case (mix)
            VAL_SMALL: return $urandom_range(15);
            VAL_EDGE: begin
                case ($urandom_range(2))
                    0:       return '0;
                    1:       return '1;
                    default: return $urandom;
                endcase
            end
            default:   return $urandom;
        endcase
    endfunction

    // Partition DP over the stored prefix sums, two columns at a time.
    function automatic t_split_result min_largest_sum(int unsigned n, int unsigned m);
        t_split_result  res;
        bit [SUM_W:0]   best;
        bit [SUM_W:0]   cand;
        bit [SUM_W-1:0] part;
        int unsigned    parts;
        int unsigned    i;
        int unsigned    j;
        int unsigned    k;
        res = '0;
        parts = (m > MAX_PARTS) ? MAX_PARTS : m;
        if (parts == 0 || n < parts) begin
            res.infeasible = 1'b1;
            return res;
        end
        col_prev[0] = '0;
        for (i = 1; i <= n; i++) col_prev[i] = UNREACHABLE;
        for (j = 1; j <= parts; j++) begin
            for (i = 0; i <= n; i++) begin
                best = UNREACHABLE;
                if (i >= j) begin
                    for (k = j - 1; k < i; k++) begin
                        if (!col_prev[k][SUM_W]) begin
                            part = seq_prefix[i] - seq_prefix[k];
                            cand = (col_prev[k] > {1'b0, part}) ? col_prev[k] : {1'b0, part};
                            if (cand < best) best = cand;
                        end
                    end
                end
                col_cur[i] = best;
            end
            for (i = 0; i <= n; i++) col_prev[i] = col_cur[i];
        end
        if (col_prev[n][SUM_W]) begin
            res.infeasible = 1'b1;
        end else begin
            res.largest_sum = col_prev[n][SUM_W-1:0];
        end
        return res;
    endfunction

    // Receiver: a long hold-off when requested, random stalls otherwise.
    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            i_stall <= 1'b1;
            rx_hold_left <= rx_hold_left - 1;
        end else begin
            i_stall <= ($urandom_range(99) < idle_pct(idle_mode, 1'b1));
        end
    end

    always @(posedge i_clk) begin
        t_split_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (split_results_due.size() == 0) begin
                $display("%0t: ERROR unexpected result: expected none, got sum %h infeasible %b",
                         $time, o_best_largest_sum, o_infeasible);
                error_count++;
            end else begin
                want = split_results_due.pop_front();
                results_checked++;
                if (o_best_largest_sum !== want.largest_sum) begin
                    $display("%0t: ERROR best_largest_sum expected %h got %h",
                             $time, want.largest_sum, o_best_largest_sum);
                    error_count++;
                end
                if (o_infeasible !== want.infeasible) begin
                    $display("%0t: ERROR infeasible expected %b got %b",
                             $time, want.infeasible, o_infeasible);
                    error_count++;
                end
            end
        end
    end

    task automatic send_word(input bit [VAL_W-1:0] v, input bit lst);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct(idle_mode, 1'b0)) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= v;
        i_last  <= lst;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        // Words past the store depth are dropped but still count for last.
        if (seq_len < MAX_ITEMS) begin
            seq_prefix[seq_len + 1] = seq_prefix[seq_len] + v;
            seq_len++;
        end
        words_sent++;
        if (lst) begin
            split_results_due.insert(split_results_due.size(),
                                     min_largest_sum(seq_len, parts_setting));
            seq_len = 0;
        end
    endtask

    task automatic send_sequence(input int unsigned len, input t_value_mix mix);
        for (int unsigned n = 1; n <= len; n++) send_word(random_value(mix), n == len);
    endtask

    task automatic finish_phase();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (split_results_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic reconfigure(input bit [CFG_W-1:0] parts);
        finish_phase();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= parts;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        parts_setting = parts;
    endtask

    task automatic test_reset_default();
        send_word('1, 1'b1);
        send_word('0, 1'b0);
        send_word('0, 1'b1);
    endtask

    task automatic test_small_splits();
        reconfigure(2);
        for (int unsigned v = 1; v <= 5; v++) send_word(v, v == 5);
        repeat (2) send_word('1, 1'b0);
        send_word('1, 1'b1);
        reconfigure(3);
        send_word(7, 1'b0);
        send_word(2, 1'b0);
        send_word(5, 1'b0);
        send_word(10, 1'b0);
        send_word(8, 1'b1);
    endtask

    task automatic test_infeasible_counts();
        send_word(4, 1'b0);
        send_word(4, 1'b1);
        reconfigure(0);
        send_word(6, 1'b1);
        reconfigure(64);
        send_word(1, 1'b0);
        send_word(2, 1'b0);
        send_word(3, 1'b1);
    endtask

    task automatic test_random_sequences();
        int unsigned  target;
        int unsigned  pick;
        bit [CFG_W-1:0] parts;
        for (int mi = 0; mi < 4; mi++) begin
            idle_mode = t_idle_mode'(mi);
            target = words_sent + 70;
            while (words_sent < target) begin
                pick = $urandom_range(99);
                if (pick < 5)       parts = '0;
                else if (pick < 10) parts = ($urandom_range(1) != 0) ? 7'd127 : 7'd64;
                else if (pick < 25) parts = CFG_W'($urandom_range(7, 12));
                else                parts = CFG_W'($urandom_range(1, 6));
                reconfigure(parts);
                repeat ($urandom_range(3, 6))
                    send_sequence($urandom_range(1, 10), t_value_mix'($urandom_range(2)));
            end
        end
        idle_mode = MIX_STEADY;
    endtask

    // Hold the output long enough that the result register and the DP both back up.
    task automatic test_output_backpressure();
        reconfigure(2);
        @(posedge i_clk);
        rx_hold_left = 1500;
        repeat (6) send_sequence(4, VAL_FULL);
    endtask

    task automatic test_long_sequences();
        reconfigure(3);
        send_sequence(120, VAL_FULL);
        send_sequence(3, VAL_EDGE);
        reconfigure(127);
        send_sequence(MAX_PARTS, VAL_FULL);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_valid       = 1'b0;
        i_value       = '0;
        i_last        = 1'b0;
        i_stall       = 1'b0;
        idle_mode     = MIX_STEADY;
        rx_hold_left  = 0;
        words_sent    = 0;
        results_checked = 0;
        error_count   = 0;
        cycle_count   = 0;
        seq_prefix[0] = '0;
        seq_len       = 0;
        parts_setting = 1;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_default();
        test_small_splits();
        test_infeasible_counts();
        test_random_sequences();
        test_output_backpressure();
        test_long_sequences();
        finish_phase();

        $display("Checked %0d results over %0d words; part counts 0, 1-12, 64 and 127,",
                 results_checked, words_sent);
        $display("idle and stall mixes, a long output hold-off and sequences up to 120 words.");
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/spm_pkg.sv
rtl/spm_ram.sv
rtl/spm_unit.sv
rtl/split_array_min_largest_sum.sv
dv/split_array_min_largest_sum_tb.sv
